>>> rtl/nfv_pkg.sv
// Shared types and constants for the Simpson velocity update block.
// Used by nfv_lane, nfv_mrg and nav_frame_velocity_simpson; no dependencies.
package nfv_pkg;

    localparam int W_DATA = 32;
    localparam int W_STEP = 24;
    localparam int W_C    = 40;   // combined delta velocity fed to a lane, Q.20
    localparam int W_ROT  = 46;   // rotated vector entry, Q.24
    localparam int W_COR  = 40;   // Coriolis term, Q.16
    localparam int W_DIV  = 44;   // offset dividend of the divide-by-three loop
    localparam int W_CNT  = 5;
    localparam int N_QP   = 9;    // quaternion products per lane

    // Sequencer timeline, as values of the step counter that is cleared when an epoch is accepted
    localparam logic [W_CNT-1:0] CYC_DV0  = 5'd0;
    localparam logic [W_CNT-1:0] CYC_DV1  = 5'd1;
    localparam logic [W_CNT-1:0] CYC_PC   = 5'd2;
    localparam logic [W_CNT-1:0] CYC_PD   = 5'd3;
    localparam logic [W_CNT-1:0] CYC_COR  = 5'd4;
    localparam logic [W_CNT-1:0] CYC_PE   = 5'd5;
    localparam logic [W_CNT-1:0] CYC_MAT  = 5'd9;
    localparam logic [W_CNT-1:0] CYC_ACC  = 5'd10;
    localparam logic [W_CNT-1:0] CYC_SUM  = 5'd19;
    localparam logic [W_CNT-1:0] CYC_DIV  = 5'd20;
    localparam logic [W_CNT-1:0] CYC_DEND = 5'd30;
    localparam logic [W_CNT-1:0] CYC_LAST = 5'd31;

    typedef logic signed [W_DATA-1:0] t_s32;

    typedef enum logic [2:0] {
        REG_GRAV_N   = 3'd0,
        REG_GRAV_E   = 3'd1,
        REG_GRAV_D   = 3'd2,
        REG_EARTH_N  = 3'd3,
        REG_EARTH_E  = 3'd4,
        REG_EARTH_D  = 3'd5,
        REG_COR_OFF  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic        [W_STEP-1:0] time_step;
        logic signed [W_DATA-1:0] accel_body_x;
        logic signed [W_DATA-1:0] accel_body_y;
        logic signed [W_DATA-1:0] accel_body_z;
        logic signed [W_DATA-1:0] quat_w;
        logic signed [W_DATA-1:0] quat_x;
        logic signed [W_DATA-1:0] quat_y;
        logic signed [W_DATA-1:0] quat_z;
        logic signed [W_DATA-1:0] transport_north;
        logic signed [W_DATA-1:0] transport_east;
        logic signed [W_DATA-1:0] transport_down;
    } t_in;

    typedef struct packed {
        logic signed [W_DATA-1:0] vel_north;
        logic signed [W_DATA-1:0] vel_east;
        logic signed [W_DATA-1:0] vel_down;
        logic                     saturated;
    } t_out;

    typedef struct packed {
        logic       q_en;
        logic [3:0] q_sel;
        logic       m_en;
        logic [3:0] m_sel;
        logic [1:0] c_col;
        logic       acc_en;
        logic       acc_clr;
        logic [1:0] acc_row;
    } t_lane_ctl;

    typedef struct packed {
        logic dv0;
        logic dv1;
        logic pc;
        logic pd;
        logic cor;
        logic pe;
        logic div_load;
        logic div_step;
    } t_mrg_ctl;

endpackage

>>> rtl/nfv_lane.sv
// One rotation lane: builds the rotation matrix of a quaternion and applies it
// to a delta-velocity vector with a single shared multiplier. Depends on nfv_pkg.
module nfv_lane (
    input  logic                                 i_clk,
    input  nfv_pkg::t_lane_ctl                   i_ctl,
    input  nfv_pkg::t_s32                        i_quat [4],
    input  logic signed [nfv_pkg::W_C-1:0]       i_vec  [3],
    output logic signed [nfv_pkg::W_ROT-1:0]     o_rot  [3]
);
    import nfv_pkg::*;

    localparam logic signed [63:0] ONE = 64'sd1 <<< 60;

    logic signed [61:0]        r_qp [N_QP];
    logic signed [63:0]        r_prod;
    logic signed [63:0]        r_acc [3];

    logic signed [63:0]        xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [63:0]        m_full [N_QP];
    logic signed [W_DATA-1:0]  m_rnd  [N_QP];
    logic signed [W_DATA-1:0]  m_pick;
    logic signed [W_DATA-1:0]  qa, qb;
    logic signed [W_C-1:0]     mul_a;
    logic signed [W_DATA-1:0]  mul_b;
    logic signed [W_C+W_DATA-1:0] mul_p;

    assign xx = 64'(r_qp[0]);
    assign yy = 64'(r_qp[1]);
    assign zz = 64'(r_qp[2]);
    assign xy = 64'(r_qp[3]);
    assign xz = 64'(r_qp[4]);
    assign yz = 64'(r_qp[5]);
    assign wx = 64'(r_qp[6]);
    assign wy = 64'(r_qp[7]);
    assign wz = 64'(r_qp[8]);

    assign m_full[0] = ONE - ((yy + zz) <<< 1);
    assign m_full[1] = (xy - wz) <<< 1;
    assign m_full[2] = (xz + wy) <<< 1;
    assign m_full[3] = (xy + wz) <<< 1;
    assign m_full[4] = ONE - ((xx + zz) <<< 1);
    assign m_full[5] = (yz - wx) <<< 1;
    assign m_full[6] = (xz - wy) <<< 1;
    assign m_full[7] = (yz + wx) <<< 1;
    assign m_full[8] = ONE - ((xx + yy) <<< 1);

    // Q.60 to Q.22, round half up
    for (genvar k = 0; k < N_QP; k++) begin : g_mrnd
        assign m_rnd[k] = W_DATA'((m_full[k] + (64'sd1 <<< 37)) >>> 38);
    end

    always_comb begin
        case (i_ctl.q_sel)
            4'd0:    begin qa = i_quat[1]; qb = i_quat[1]; end
            4'd1:    begin qa = i_quat[2]; qb = i_quat[2]; end
            4'd2:    begin qa = i_quat[3]; qb = i_quat[3]; end
            4'd3:    begin qa = i_quat[1]; qb = i_quat[2]; end
            4'd4:    begin qa = i_quat[1]; qb = i_quat[3]; end
            4'd5:    begin qa = i_quat[2]; qb = i_quat[3]; end
            4'd6:    begin qa = i_quat[0]; qb = i_quat[1]; end
            4'd7:    begin qa = i_quat[0]; qb = i_quat[2]; end
            4'd8:    begin qa = i_quat[0]; qb = i_quat[3]; end
            default: begin qa = i_quat[0]; qb = i_quat[0]; end
        endcase
        case (i_ctl.m_sel)
            4'd0:    m_pick = m_rnd[0];
            4'd1:    m_pick = m_rnd[1];
            4'd2:    m_pick = m_rnd[2];
            4'd3:    m_pick = m_rnd[3];
            4'd4:    m_pick = m_rnd[4];
            4'd5:    m_pick = m_rnd[5];
            4'd6:    m_pick = m_rnd[6];
            4'd7:    m_pick = m_rnd[7];
            4'd8:    m_pick = m_rnd[8];
            default: m_pick = '0;
        endcase
        if (i_ctl.q_en) begin
            mul_a = W_C'(qa);
            mul_b = qb;
        end else begin
            mul_a = i_vec[i_ctl.c_col];
            mul_b = m_pick;
        end
    end

    assign mul_p = (W_C+W_DATA)'(mul_a) * (W_C+W_DATA)'(mul_b);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_QP; k++) begin
            if (i_ctl.q_en && i_ctl.q_sel == 4'(k)) begin
                r_qp[k] <= mul_p[61:0];
            end
        end
        if (i_ctl.m_en) begin
            r_prod <= mul_p[63:0];
        end
        for (int r = 0; r < 3; r++) begin
            if (i_ctl.acc_en && i_ctl.acc_row == 2'(r)) begin
                r_acc[r] <= (i_ctl.acc_clr ? 64'sd0 : r_acc[r]) + r_prod;
            end
        end
    end

    // Q.42 to Q.24
    for (genvar r = 0; r < 3; r++) begin : g_out
        assign o_rot[r] = W_ROT'((r_acc[r] + (64'sd1 <<< 17)) >>> 18);
    end

endmodule

>>> rtl/nfv_mrg.sv
// Per-component merge: delta velocities, Coriolis and gravity terms, Simpson
// combination of the lane results, divide by 1536, saturation. Depends on nfv_pkg.
module nfv_mrg #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  nfv_pkg::t_mrg_ctl                 i_ctl,
    input  nfv_pkg::t_s32                     i_accel      [3],
    input  nfv_pkg::t_s32                     i_accel_last [3],
    input  logic [nfv_pkg::W_STEP-1:0]        i_step,
    input  logic [nfv_pkg::W_STEP-1:0]        i_step_last,
    input  nfv_pkg::t_s32                     i_trans      [3],
    input  nfv_pkg::t_s32                     i_earth      [3],
    input  nfv_pkg::t_s32                     i_grav       [3],
    input  logic                              i_cor_off,
    input  nfv_pkg::t_s32                     i_vel_last   [3],
    input  nfv_pkg::t_s32                     i_vel_bl     [3],
    input  logic signed [nfv_pkg::W_ROT-1:0]  i_rot        [3][3],
    output logic signed [nfv_pkg::W_C-1:0]    o_vec        [3][3],
    output nfv_pkg::t_s32                     o_vel        [3],
    output logic                              o_sat
);
    import nfv_pkg::*;

    localparam int SAT_W = (VALUE_WIDTH < W_DATA) ? VALUE_WIDTH : W_DATA;
    localparam int W_X   = 46;
    localparam logic signed [W_X-1:0] VMAX = (W_X'(1) <<< (SAT_W - 1)) - W_X'(1);
    localparam logic signed [W_X-1:0] VMIN = -VMAX - W_X'(1);
    localparam logic [W_DIV-1:0] DIV_OFS = W_DIV'(3) << 40;

    // four quotient bits of a restoring divide by three
    function automatic logic [5:0] div3_step(input logic [1:0] rem_in, input logic [3:0] dig);
        logic [2:0] r;
        logic [3:0] q;
        r = {1'b0, rem_in};
        q = '0;
        for (int b = 3; b >= 0; b--) begin
            r = {r[1:0], dig[b]};
            if (r >= 3'd3) begin
                r = r - 3'd3;
                q[b] = 1'b1;
            end
        end
        return {q, r[1:0]};
    endfunction

    logic signed [W_DATA-1:0] wr [3];
    logic signed [W_DATA-1:0] step_s, step_last_s, total_s;
    logic [2:0] clip;

    assign step_s      = $signed({8'b0, i_step});
    assign step_last_s = $signed({8'b0, i_step_last});
    assign total_s     = $signed({7'b0, {1'b0, i_step} + {1'b0, i_step_last}});

    for (genvar i = 0; i < 3; i++) begin : g_wr
        assign wr[i] = W_DATA'(((35'(i_earth[i]) <<< 1) + 35'(i_trans[i]) + 35'sd8) >>> 4);
    end

    for (genvar i = 0; i < 3; i++) begin : g_comp
        localparam int J1 = (i + 1) % 3;
        localparam int J2 = (i + 2) % 3;

        logic signed [56:0]      r_pa, r_pb;
        logic signed [63:0]      r_pc, r_pd, r_pe;
        logic signed [W_COR-1:0] r_cor;
        logic [W_DIV-1:0]        r_u, r_q;
        logic [1:0]              r_rem;

        logic signed [40:0]      mul_a, cor_g;
        logic signed [W_DATA-1:0] mul_b;
        logic signed [72:0]      mul_p;
        logic signed [36:0]      dv0, dv1;
        logic signed [63:0]      cdiff;
        logic signed [W_COR-1:0] dterm;
        logic signed [49:0]      ssum;
        logic [W_DIV-1:0]        u;
        logic signed [W_DIV-1:0] s;
        logic signed [W_X-1:0]   x;
        logic [5:0]              dstep;

        assign cor_g = 41'(r_cor) - 41'(i_grav[i]);

        always_comb begin
            mul_a = 41'(i_accel[i]);
            mul_b = step_s;
            if (i_ctl.dv1) begin
                mul_a = 41'(i_accel_last[i]);
                mul_b = step_last_s;
            end else if (i_ctl.pc) begin
                mul_a = 41'(wr[J1]);
                mul_b = i_vel_last[J2];
            end else if (i_ctl.pd) begin
                mul_a = 41'(wr[J2]);
                mul_b = i_vel_last[J1];
            end else if (i_ctl.pe) begin
                mul_a = cor_g;
                mul_b = total_s;
            end
        end

        assign mul_p = 73'(mul_a) * 73'(mul_b);

        assign dv0   = 37'((r_pa + 57'sd524288) >>> 20);
        assign dv1   = 37'((r_pb + 57'sd524288) >>> 20);
        assign cdiff = r_pc - r_pd;
        assign dterm = W_COR'((r_pe + 64'sd8388608) >>> 24);

        assign o_vec[0][i] = (W_C'(dv1) <<< 1) + W_C'(dv1) - W_C'(dv0);
        assign o_vec[1][i] = W_C'(dv1) + W_C'(dv0);
        assign o_vec[2][i] = (W_C'(dv0) <<< 1) + W_C'(dv0) - W_C'(dv1);

        // 1-4-1 sum, then floor((sum + 768) / 1536) = floor(floor(./512) / 3)
        assign ssum  = 50'(i_rot[0][i]) + (50'(i_rot[1][i]) <<< 2) + 50'(i_rot[2][i]);
        assign u     = W_DIV'((ssum + 50'sd768) >>> 9) + DIV_OFS;
        assign dstep = div3_step(r_rem, r_u[W_DIV-1 -: 4]);
        assign s     = $signed(r_q - (W_DIV'(1) << 40));

        assign x = W_X'(i_vel_bl[i]) + W_X'(s) - W_X'(dterm);

        always_ff @(posedge i_clk) begin
            if (i_ctl.dv0) begin
                r_pa <= mul_p[56:0];
            end
            if (i_ctl.dv1) begin
                r_pb <= mul_p[56:0];
            end
            if (i_ctl.pc) begin
                r_pc <= mul_p[63:0];
            end
            if (i_ctl.pd) begin
                r_pd <= mul_p[63:0];
            end
            if (i_ctl.cor) begin
                r_cor <= i_cor_off ? '0 : W_COR'((cdiff + 64'sd8388608) >>> 24);
            end
            if (i_ctl.pe) begin
                r_pe <= mul_p[63:0];
            end
            if (i_ctl.div_load) begin
                r_u   <= u;
                r_rem <= 2'd0;
            end else if (i_ctl.div_step) begin
                r_u   <= r_u << 4;
                r_q   <= {r_q[W_DIV-5:0], dstep[5:2]};
                r_rem <= dstep[1:0];
            end
        end

        always_comb begin
            clip[i]  = 1'b0;
            o_vel[i] = W_DATA'(x);
            if (x > VMAX) begin
                clip[i]  = 1'b1;
                o_vel[i] = W_DATA'(VMAX);
            end else if (x < VMIN) begin
                clip[i]  = 1'b1;
                o_vel[i] = W_DATA'(VMIN);
            end
        end
    end

    assign o_sat = |clip;

endmodule

>>> rtl/nav_frame_velocity_simpson.sv
// Top level of the Simpson navigation-frame velocity update.
// Instantiates three nfv_lane rotation lanes and nfv_mrg; depends on nfv_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in_data) takes one
//   inertial epoch per transaction. Output channel (o_out_valid /
//   i_out_ready, payload o_out_data) returns one velocity per epoch.
//   Configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while no epoch is in flight; the user must keep to this,
//   as the block does not enforce it. Unknown indices are ignored.
//   The 32-step sequencer runs nine quaternion products and nine
//   matrix-vector products per lane on one multiplier, then eleven
//   steps of the four-bit divide-by-three loop. It takes a new epoch
//   only once the previous one has finished its last step.
//   The output register decouples the sides: a new epoch is taken while a
//   result waits. If the receiver stalls longer than one epoch, the next
//   result holds in the last sequencer step until the register frees up.
//   Reset (synchronous, active low) clears the history and loads the
//   default register values (down gravity 9.81 m/s^2).
module nav_frame_velocity_simpson #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nfv_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nfv_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [nfv_pkg::W_DATA-1:0]    i_cfg_data
);
    import nfv_pkg::*;

    localparam t_s32 Q_LIM = 32'sd1073741824;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state             r_state;
    logic [W_CNT-1:0]   r_cnt;
    t_in                r_item;
    t_out               r_out;
    logic               r_out_valid;

    t_s32               r_grav  [3];
    t_s32               r_earth [3];
    logic               r_cor_off;

    t_s32               r_vel_last   [3];
    t_s32               r_vel_bl     [3];
    t_s32               r_accel_last [3];
    t_s32               r_quat_last  [4];
    t_s32               r_quat_bl    [4];
    logic [W_STEP-1:0]  r_step_last;

    t_s32               raw_q   [4];
    t_s32               cur_q   [4];
    t_s32               cur_acc [3];
    t_s32               cur_tr  [3];
    t_s32               lane_q  [3][4];
    logic signed [W_C-1:0]   lane_vec [3][3];
    logic signed [W_ROT-1:0] lane_rot [3][3];
    t_s32               new_vel [3];
    logic               new_sat;

    t_lane_ctl          lane_ctl;
    t_mrg_ctl           mrg_ctl;
    logic               run, accept, finish;
    logic [3:0]         mat_k, acc_k;

    function automatic t_s32 clamp_q(input t_s32 v);
        if (v > Q_LIM) begin
            return Q_LIM;
        end
        if (v < -Q_LIM) begin
            return -Q_LIM;
        end
        return v;
    endfunction

    assign raw_q[0] = r_item.quat_w;
    assign raw_q[1] = r_item.quat_x;
    assign raw_q[2] = r_item.quat_y;
    assign raw_q[3] = r_item.quat_z;
    assign cur_acc[0] = r_item.accel_body_x;
    assign cur_acc[1] = r_item.accel_body_y;
    assign cur_acc[2] = r_item.accel_body_z;
    assign cur_tr[0]  = r_item.transport_north;
    assign cur_tr[1]  = r_item.transport_east;
    assign cur_tr[2]  = r_item.transport_down;

    for (genvar k = 0; k < 4; k++) begin : g_quat
        assign cur_q[k]     = clamp_q(raw_q[k]);
        assign lane_q[0][k] = r_quat_bl[k];
        assign lane_q[1][k] = r_quat_last[k];
        assign lane_q[2][k] = cur_q[k];
    end

    assign run        = r_state == S_RUN;
    assign o_in_ready = r_state == S_IDLE;
    assign accept     = i_in_valid && o_in_ready;
    assign finish     = run && r_cnt == CYC_LAST && (!r_out_valid || i_out_ready);

    // sequencer decode
    assign mat_k = 4'(r_cnt - CYC_MAT);
    assign acc_k = 4'(r_cnt - CYC_ACC);

    always_comb begin
        lane_ctl.q_en   = run && r_cnt < CYC_MAT;
        lane_ctl.q_sel  = r_cnt[3:0];
        lane_ctl.m_en   = run && r_cnt >= CYC_MAT && r_cnt < CYC_ACC + 5'd8;
        lane_ctl.m_sel  = mat_k;
        lane_ctl.acc_en = run && r_cnt >= CYC_ACC && r_cnt < CYC_SUM;
        case (mat_k) inside
            4'd0, 4'd3, 4'd6: lane_ctl.c_col = 2'd0;
            4'd1, 4'd4, 4'd7: lane_ctl.c_col = 2'd1;
            default:          lane_ctl.c_col = 2'd2;
        endcase
        case (acc_k) inside
            4'd0, 4'd3, 4'd6: lane_ctl.acc_clr = 1'b1;
            default:          lane_ctl.acc_clr = 1'b0;
        endcase
        if (acc_k < 4'd3) begin
            lane_ctl.acc_row = 2'd0;
        end else if (acc_k < 4'd6) begin
            lane_ctl.acc_row = 2'd1;
        end else begin
            lane_ctl.acc_row = 2'd2;
        end

        mrg_ctl.dv0      = run && r_cnt == CYC_DV0;
        mrg_ctl.dv1      = run && r_cnt == CYC_DV1;
        mrg_ctl.pc       = run && r_cnt == CYC_PC;
        mrg_ctl.pd       = run && r_cnt == CYC_PD;
        mrg_ctl.cor      = run && r_cnt == CYC_COR;
        mrg_ctl.pe       = run && r_cnt == CYC_PE;
        mrg_ctl.div_load = run && r_cnt == CYC_SUM;
        mrg_ctl.div_step = run && r_cnt >= CYC_DIV && r_cnt <= CYC_DEND;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        nfv_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_quat (lane_q[l]),
            .i_vec  (lane_vec[l]),
            .o_rot  (lane_rot[l])
        );
    end

    nfv_mrg #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mrg (
        .i_clk        (i_clk),
        .i_ctl        (mrg_ctl),
        .i_accel      (cur_acc),
        .i_accel_last (r_accel_last),
        .i_step       (r_item.time_step),
        .i_step_last  (r_step_last),
        .i_trans      (cur_tr),
        .i_earth      (r_earth),
        .i_grav       (r_grav),
        .i_cor_off    (r_cor_off),
        .i_vel_last   (r_vel_last),
        .i_vel_bl     (r_vel_bl),
        .i_rot        (lane_rot),
        .o_vec        (lane_vec),
        .o_vel        (new_vel),
        .o_sat        (new_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_grav[0]   <= '0;
            r_grav[1]   <= '0;
            r_grav[2]   <= 32'sd642908;
            r_cor_off   <= 1'b0;
            r_step_last <= '0;
            for (int i = 0; i < 3; i++) begin
                r_earth[i]      <= '0;
                r_vel_last[i]   <= '0;
                r_vel_bl[i]     <= '0;
                r_accel_last[i] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_quat_last[k] <= '0;
                r_quat_bl[k]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_GRAV_N:  r_grav[0]  <= i_cfg_data;
                    REG_GRAV_E:  r_grav[1]  <= i_cfg_data;
                    REG_GRAV_D:  r_grav[2]  <= i_cfg_data;
                    REG_EARTH_N: r_earth[0] <= i_cfg_data;
                    REG_EARTH_E: r_earth[1] <= i_cfg_data;
                    REG_EARTH_D: r_earth[2] <= i_cfg_data;
                    REG_COR_OFF: r_cor_off  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                    end
                end
                S_RUN: begin
                    if (r_cnt != CYC_LAST) begin
                        r_cnt <= r_cnt + 5'd1;
                    end else if (finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // epoch history shifts when the result is committed
            if (finish) begin
                r_step_last <= r_item.time_step;
                for (int i = 0; i < 3; i++) begin
                    r_vel_bl[i]     <= r_vel_last[i];
                    r_vel_last[i]   <= new_vel[i];
                    r_accel_last[i] <= cur_acc[i];
                end
                for (int k = 0; k < 4; k++) begin
                    r_quat_bl[k]   <= r_quat_last[k];
                    r_quat_last[k] <= cur_q[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
        end
        if (finish) begin
            r_out.vel_north <= new_vel[0];
            r_out.vel_east  <= new_vel[1];
            r_out.vel_down  <= new_vel[2];
            r_out.saturated <= new_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> test/nav_frame_velocity_simpson_tb.sv
// Self-checking testbench for nav_frame_velocity_simpson.
// Holds its own bit-accurate velocity predictor; depends on nfv_pkg and the RTL only.
module nav_frame_velocity_simpson_tb;
    import nfv_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    logic        calm;       // no idling on either side while set
    logic        failed;
    int          quiet_cycles;
    t_out        vel_expected[$];

    // predictor copy of registers and history
    wide_t grav[3], earth[3];
    logic  cor_off;
    wide_t vel_l[3], vel_bl[3], acc_l[3], quat_l[4], quat_bl[4], step_l;

    nav_frame_velocity_simpson u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic wide_t rnd_shift(input wide_t x, input int s);
        return (x + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic wide_t rnd_div1536(input wide_t x);
        wide_t y, q;
        y = x + 768;
        q = y / 1536;
        if (y < 0 && q * 1536 != y) q = q - 1;
        return q;
    endfunction

    function automatic void rotate_vec(input wide_t q[4], input wide_t c[3],
                                       output wide_t r[3]);
        wide_t m[9];
        wide_t one, w, x, y, z;
        one = wide_t'(1) <<< 60;
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        // all-zero quaternion degenerates to identity on purpose
        m[0] = one - 2 * (y * y + z * z);
        m[1] = 2 * (x * y - w * z);
        m[2] = 2 * (x * z + w * y);
        m[3] = 2 * (x * y + w * z);
        m[4] = one - 2 * (x * x + z * z);
        m[5] = 2 * (y * z - w * x);
        m[6] = 2 * (x * z - w * y);
        m[7] = 2 * (y * z + w * x);
        m[8] = one - 2 * (x * x + y * y);
        for (int i = 0; i < 9; i++) m[i] = rnd_shift(m[i], 38);
        for (int i = 0; i < 3; i++)
            r[i] = rnd_shift(m[3*i] * c[0] + m[3*i+1] * c[1] + m[3*i+2] * c[2], 18);
    endfunction

    function automatic wide_t clamp_quat(input logic signed [31:0] v);
        wide_t lim;
        lim = wide_t'(1) <<< 30;
        if (wide_t'(v) > lim) return lim;
        if (wide_t'(v) < -lim) return -lim;
        return wide_t'(v);
    endfunction

    function automatic t_out predict_velocity(input t_in d);
        wide_t dt, total, vmax, vmin, dd, xv;
        wide_t acc[3], trans[3], q[4], dv0[3], dv1[3], c[3];
        wide_t r2[3], r1[3], r0[3], s[3], wr[3], cor[3], v[3];
        t_out  res;
        dt = wide_t'({1'b0, d.time_step});
        total = dt + step_l;
        vmax = (wide_t'(1) <<< 31) - 1;
        vmin = -vmax - 1;
        res.saturated = 1'b0;
        acc[0] = wide_t'(d.accel_body_x);
        acc[1] = wide_t'(d.accel_body_y);
        acc[2] = wide_t'(d.accel_body_z);
        trans[0] = wide_t'(d.transport_north);
        trans[1] = wide_t'(d.transport_east);
        trans[2] = wide_t'(d.transport_down);
        q[0] = clamp_quat(d.quat_w);
        q[1] = clamp_quat(d.quat_x);
        q[2] = clamp_quat(d.quat_y);
        q[3] = clamp_quat(d.quat_z);
        for (int i = 0; i < 3; i++) begin
            dv0[i] = rnd_shift(acc[i] * dt, 20);
            dv1[i] = rnd_shift(acc_l[i] * step_l, 20);
        end
        for (int i = 0; i < 3; i++) c[i] = 3 * dv1[i] - dv0[i];
        rotate_vec(quat_bl, c, r2);
        for (int i = 0; i < 3; i++) c[i] = dv1[i] + dv0[i];
        rotate_vec(quat_l, c, r1);
        for (int i = 0; i < 3; i++) c[i] = 3 * dv0[i] - dv1[i];
        rotate_vec(q, c, r0);
        for (int i = 0; i < 3; i++) begin
            s[i]  = rnd_div1536(r2[i] + 4 * r1[i] + r0[i]);
            wr[i] = rnd_shift(2 * earth[i] + trans[i], 4);
        end
        if (cor_off) begin
            cor[0] = 0; cor[1] = 0; cor[2] = 0;
        end else begin
            cor[0] = rnd_shift(wr[1] * vel_l[2] - wr[2] * vel_l[1], 24);
            cor[1] = rnd_shift(wr[2] * vel_l[0] - wr[0] * vel_l[2], 24);
            cor[2] = rnd_shift(wr[0] * vel_l[1] - wr[1] * vel_l[0], 24);
        end
        for (int i = 0; i < 3; i++) begin
            dd = rnd_shift((cor[i] - grav[i]) * total, 24);
            xv = vel_bl[i] + s[i] - dd;
            if (xv > vmax) begin xv = vmax; res.saturated = 1'b1; end
            if (xv < vmin) begin xv = vmin; res.saturated = 1'b1; end
            v[i] = xv;
        end
        for (int i = 0; i < 3; i++) begin
            vel_bl[i] = vel_l[i];
            vel_l[i] = v[i];
            acc_l[i] = acc[i];
        end
        for (int i = 0; i < 4; i++) begin
            quat_bl[i] = quat_l[i];
            quat_l[i] = q[i];
        end
        step_l = dt;
        res.vel_north = v[0][31:0];
        res.vel_east  = v[1][31:0];
        res.vel_down  = v[2][31:0];
        return res;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_epoch(input t_in d);
        if (!calm && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 33) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        // ready as seen at the edge, before the block updates
        @(posedge i_clk iff in_ready);
        vel_expected.push_back(predict_velocity(d));
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (vel_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_GRAV_N:  grav[0]  = wide_t'($signed(val));
            REG_GRAV_E:  grav[1]  = wide_t'($signed(val));
            REG_GRAV_D:  grav[2]  = wide_t'($signed(val));
            REG_EARTH_N: earth[0] = wide_t'($signed(val));
            REG_EARTH_E: earth[1] = wide_t'($signed(val));
            REG_EARTH_D: earth[2] = wide_t'($signed(val));
            REG_COR_OFF: cor_off  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] gn, ge, gd, en, ee, ed,
                              input logic coff);
        cfg_write(REG_GRAV_N, gn);
        cfg_write(REG_GRAV_E, ge);
        cfg_write(REG_GRAV_D, gd);
        cfg_write(REG_EARTH_N, en);
        cfg_write(REG_EARTH_E, ee);
        cfg_write(REG_EARTH_D, ed);
        cfg_write(REG_COR_OFF, {31'd0, coff});
        // out-of-list index must leave everything alone
        cfg_write(REG_UNUSED, $urandom);
        cfg_we <= 1'b0;
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic logic [31:0] srand(input int unsigned mag);
        return $urandom_range(0, 2 * mag) - mag;
    endfunction

    function automatic t_in plausible_epoch();
        t_in d;
        d.time_step       = $urandom_range(1, 40000);
        d.accel_body_x    = srand(20 << 16);
        d.accel_body_y    = srand(20 << 16);
        d.accel_body_z    = srand(20 << 16);
        d.quat_w          = srand(1 << 30);
        d.quat_x          = srand(1 << 30);
        d.quat_y          = srand(1 << 30);
        d.quat_z          = srand(1 << 30);
        d.transport_north = srand(1 << 20);
        d.transport_east  = srand(1 << 20);
        d.transport_down  = srand(1 << 20);
        return d;
    endfunction

    function automatic t_in noise_epoch();
        t_in d;
        logic [351:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        d = raw[$bits(t_in)-1:0];
        return d;
    endfunction

    // ---------------- tests ----------------
    task automatic test_fresh_history();
        t_in d;
        // zero history: old quaternions act as identity
        for (int k = 0; k < 3; k++) begin
            d = plausible_epoch();
            d.quat_w = 32'sd1073741824; d.quat_x = 0; d.quat_y = 0; d.quat_z = 0;
            send_epoch(d);
        end
        d = '0;
        send_epoch(d);
        stop_input();
        wait_idle();
    endtask

    task automatic test_field_extremes();
        t_in d;
        d = '1;
        send_epoch(d);
        d = '0;
        d.time_step = '1;
        d.accel_body_x = 32'sh7fffffff; d.accel_body_y = 32'sh80000000;
        d.accel_body_z = 32'sh7fffffff;
        d.quat_w = 32'sh40000000; d.quat_x = 32'shc0000000;
        d.quat_y = 32'sh40000000; d.quat_z = 32'shc0000000;
        d.transport_north = 32'sh7fffffff; d.transport_east = 32'sh80000000;
        d.transport_down = 32'sh7fffffff;
        send_epoch(d);
        send_epoch(d);
        d.accel_body_x = 32'sh80000000; d.accel_body_y = 32'sh7fffffff;
        d.accel_body_z = 32'sh80000000;
        send_epoch(d);
        send_epoch(d);
        stop_input();
        wait_idle();
    endtask

    task automatic test_quat_clamp();
        t_in d;
        d = plausible_epoch();
        d.quat_w = 32'sh7fffffff; d.quat_x = 32'sh80000000;
        d.quat_y = 32'sh40000001; d.quat_z = 32'shbfffffff;
        send_epoch(d);
        d = plausible_epoch();
        send_epoch(d);
        send_epoch(plausible_epoch());
        stop_input();
        wait_idle();
    endtask

    task automatic test_coriolis_and_gravity();
        set_config(32'sd1000, -32'sd2000, 32'sd642908, 32'sd19577, 32'sd0,
                   -32'sd19577, 1'b0);
        for (int k = 0; k < 5; k++) send_epoch(plausible_epoch());
        stop_input();
        wait_idle();
        set_config(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff, 1'b0);
        for (int k = 0; k < 4; k++) send_epoch(noise_epoch());
        stop_input();
        wait_idle();
        set_config(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                   32'sh7fffffff, 32'sh80000000, 1'b1);
        for (int k = 0; k < 4; k++) send_epoch(noise_epoch());
        stop_input();
        wait_idle();
    endtask

    task automatic test_random_epochs();
        for (int phase = 0; phase < 3; phase++) begin
            set_config(srand(1 << 16), srand(1 << 16), $urandom_range(600000, 680000),
                       srand(1 << 18), srand(1 << 18), srand(1 << 18),
                       phase == 2);
            for (int k = 0; k < 140; k++) begin
                calm <= (phase == 1 && k >= 40 && k < 100);
                if ($urandom_range(99) < 10) send_epoch(noise_epoch());
                else send_epoch(plausible_epoch());
            end
            stop_input();
            calm <= 1'b0;
            wait_idle();
        end
    endtask

    // ---------------- receiver, checker, watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ready <= 1'b0;
        else out_ready <= calm || ($urandom_range(99) >= 33);
    end

    always @(posedge i_clk) begin
        t_out exp_v;
        if (i_rst_n && out_valid && out_ready) begin
            if (vel_expected.size() == 0) begin
                $error("velocity result with nothing expected");
                failed = 1'b1;
            end else begin
                exp_v = vel_expected.pop_front();
                if (out_data.vel_north !== exp_v.vel_north) begin
                    $error("vel_north exp %0d got %0d", exp_v.vel_north, out_data.vel_north);
                    failed = 1'b1;
                end
                if (out_data.vel_east !== exp_v.vel_east) begin
                    $error("vel_east exp %0d got %0d", exp_v.vel_east, out_data.vel_east);
                    failed = 1'b1;
                end
                if (out_data.vel_down !== exp_v.vel_down) begin
                    $error("vel_down exp %0d got %0d", exp_v.vel_down, out_data.vel_down);
                    failed = 1'b1;
                end
                if (out_data.saturated !== exp_v.saturated) begin
                    $error("saturated exp %0b got %0b", exp_v.saturated, out_data.saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        failed = 1'b0;
        quiet_cycles = 0;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= REG_GRAV_N;
        cfg_data <= '0;
        grav[0] = 0; grav[1] = 0; grav[2] = 642908;
        for (int i = 0; i < 3; i++) begin
            earth[i] = 0; vel_l[i] = 0; vel_bl[i] = 0; acc_l[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            quat_l[i] = 0; quat_bl[i] = 0;
        end
        step_l = 0;
        cor_off = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fresh_history();
        test_field_extremes();
        test_quat_clamp();
        test_coriolis_and_gravity();
        test_random_epochs();

        if (!failed && vel_expected.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/nfv_pkg.sv
rtl/nfv_lane.sv
rtl/nfv_mrg.sv
rtl/nav_frame_velocity_simpson.sv
test/nav_frame_velocity_simpson_tb.sv
